>>> hdl/ersg_pkg.sv
`default_nettype none

package ersg_pkg;

    // field widths
    localparam int unsigned COORD_W   = 12;
    localparam int unsigned SURF_W    = 13;
    localparam int unsigned ALPHA_W   = 8;
    localparam int unsigned THICK_W   = 8;
    localparam int unsigned ROW_W     = 13;
    localparam int unsigned ADDR_W    = 24;
    localparam int unsigned CFG_W     = 13;

    // squared radii stay below 2^23, row offset squared below 2^24
    localparam int unsigned SQ_W      = 23;
    localparam int unsigned JJ_W      = 24;
    localparam int unsigned NUM_W     = SQ_W + SQ_W;
    localparam int unsigned ROOT_W    = 12;

    // pipeline depth
    localparam int unsigned DIV_STAGES = SQ_W;
    localparam int unsigned SQRT_STEPS = ROOT_W;
    localparam int unsigned SB_DEPTH   = DIV_STAGES + 1 + SQRT_STEPS;
    localparam int unsigned LATENCY    = 3 + SB_DEPTH + 1;

    localparam logic [SURF_W-1:0]  SURFACE_DIM  = 13'd4096;
    localparam logic [THICK_W-1:0] MAX_BORDER   = 8'd255;
    localparam logic [ALPHA_W-1:0] OPAQUE_ALPHA = 8'd255;

    typedef enum logic [2:0] {
        CFG_POS_X        = 3'd0,
        CFG_POS_Y        = 3'd1,
        CFG_BOX_WIDTH    = 3'd2,
        CFG_BOX_HEIGHT   = 3'd3,
        CFG_THICKNESS    = 3'd4,
        CFG_SURF_WIDTH   = 3'd5,
        CFG_FILL_ALPHA   = 3'd6,
        CFG_BORDER_ALPHA = 3'd7
    } t_cfg_idx;

    // divide request: num / den, quotient used only when ok (then it is below lim)
    typedef struct packed {
        logic              ok;
        logic [NUM_W-1:0]  num;
        logic [SQ_W-1:0]   den;
        logic [SQ_W-1:0]   lim;
    } t_div_req;

    typedef struct packed {
        logic              ok;
        logic [SQ_W-1:0]   lim;
        logic [SQ_W-1:0]   quo;
    } t_div_res;

endpackage

`default_nettype wire

>>> hdl/ellipse_row_span_generator.sv
// channel   ports                                        transfer
// config    i_cfg_we, i_cfg_idx, i_cfg_data              edge with i_cfg_we high
// row in    i_start, o_busy, i_row_offset                edge with i_start high, o_busy low
// span out  o_valid, o_row_valid .. o_border_opaque      one-cycle strobe on o_valid
//
// one row is accepted every cycle; o_valid rises after the row has passed through
// the registers in order: three front stages, the 23-stage
// divider, the limit stage, the 12-stage root and the output register
// o_busy is always low; results cannot be held off, so the pipeline never stalls
// i_rst_n is synchronous, active low; it clears valid bits and resets the configuration registers
`default_nettype none

module ellipse_row_span_generator (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [2:0]                  i_cfg_idx,
    input  wire logic [ersg_pkg::CFG_W-1:0]  i_cfg_data,
    input  wire logic                        i_start,
    output      logic                        o_busy,
    input  wire logic [ersg_pkg::ROW_W-1:0]  i_row_offset,
    output      logic                        o_valid,
    output      logic                        o_row_valid,
    output      logic [ersg_pkg::ADDR_W-1:0] o_centre_address,
    output      logic [10:0]                 o_fill_half_span,
    output      logic [11:0]                 o_outer_half_span,
    output      logic                        o_fill_opaque,
    output      logic                        o_border_opaque
);

    localparam int unsigned SQ = ersg_pkg::SQ_W;
    localparam int unsigned JJ = ersg_pkg::JJ_W;
    localparam int unsigned AW = ersg_pkg::ADDR_W;
    localparam int unsigned SB = ersg_pkg::SB_DEPTH;
    localparam int unsigned NUMW = ersg_pkg::NUM_W + 1;

    // configuration registers
    logic [11:0] r_pos_x;
    logic [11:0] r_pos_y;
    logic [11:0] r_box_width;
    logic [11:0] r_box_height;
    logic [7:0]  r_thickness;
    logic [12:0] r_surf_width;
    logic [7:0]  r_fill_alpha;
    logic [7:0]  r_border_alpha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x        <= '0;
            r_pos_y        <= '0;
            r_box_width    <= '0;
            r_box_height   <= '0;
            r_thickness    <= '0;
            r_surf_width   <= ersg_pkg::SURFACE_DIM;
            r_fill_alpha   <= ersg_pkg::OPAQUE_ALPHA;
            r_border_alpha <= '0;
        end else if (i_cfg_we) begin
            unique case (ersg_pkg::t_cfg_idx'(i_cfg_idx))
                ersg_pkg::CFG_POS_X:        r_pos_x        <= i_cfg_data[11:0];
                ersg_pkg::CFG_POS_Y:        r_pos_y        <= i_cfg_data[11:0];
                ersg_pkg::CFG_BOX_WIDTH:    r_box_width    <= i_cfg_data[11:0];
                ersg_pkg::CFG_BOX_HEIGHT:   r_box_height   <= i_cfg_data[11:0];
                ersg_pkg::CFG_THICKNESS:    r_thickness    <= i_cfg_data[7:0];
                ersg_pkg::CFG_SURF_WIDTH:   r_surf_width   <= i_cfg_data[12:0];
                ersg_pkg::CFG_FILL_ALPHA:   r_fill_alpha   <= i_cfg_data[7:0];
                ersg_pkg::CFG_BORDER_ALPHA: r_border_alpha <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_busy = 1'b0;

    // stage 1: radii, range check, flags
    logic [10:0]        w_cx;
    logic [10:0]        w_cy;
    logic [7:0]         w_t;
    logic [11:0]        w_lim;
    logic signed [13:0] w_j14;
    logic signed [13:0] w_lim14;
    logic               w_in_range;
    logic [12:0]        w_abs;
    logic               w_border_on;

    assign w_cx    = r_box_width[11:1];
    assign w_cy    = r_box_height[11:1];
    assign w_t     = (r_thickness > ersg_pkg::MAX_BORDER) ? ersg_pkg::MAX_BORDER : r_thickness;
    assign w_lim   = {1'b0, w_cy} + {4'd0, w_t};
    assign w_j14   = {i_row_offset[12], i_row_offset};
    assign w_lim14 = $signed({2'b00, w_lim});
    assign w_in_range  = (w_j14 >= -w_lim14) && (w_j14 < w_lim14);
    assign w_abs       = i_row_offset[12] ? (13'd0 - i_row_offset) : i_row_offset;
    assign w_border_on = (w_t != '0) && (r_border_alpha != '0);

    logic        r_s1_vld;
    logic        r_s1_row_ok;
    logic        r_s1_bon;
    logic        r_s1_fop;
    logic        r_s1_bop;
    logic [11:0] r_s1_absj;
    logic [10:0] r_s1_cx;
    logic [10:0] r_s1_cy;
    logic [11:0] r_s1_rxb;
    logic [11:0] r_s1_ryb;
    logic [AW-1:0] r_s1_ysum;
    logic [12:0] r_s1_sw;
    logic [12:0] r_s1_xsum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_start && !o_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_row_ok <= (r_fill_alpha != '0) && w_in_range;
        r_s1_bon    <= w_border_on;
        r_s1_fop    <= r_fill_alpha == ersg_pkg::OPAQUE_ALPHA;
        r_s1_bop    <= w_border_on && (r_border_alpha == ersg_pkg::OPAQUE_ALPHA);
        r_s1_absj   <= w_abs[11:0];
        r_s1_cx     <= w_cx;
        r_s1_cy     <= w_cy;
        r_s1_rxb    <= {1'b0, w_cx} + {4'd0, w_t};
        r_s1_ryb    <= w_lim;
        r_s1_ysum   <= {12'd0, r_pos_y} + {{11{i_row_offset[12]}}, i_row_offset};
        r_s1_sw     <= r_surf_width;
        r_s1_xsum   <= {1'b0, r_pos_x} + {2'd0, w_cx};
    end

    // stage 2: squares and row base product
    logic [21:0] w_cx_sq;
    logic [21:0] w_cy_sq;
    logic [23:0] w_rxb_sq;
    logic [23:0] w_ryb_sq;

    assign w_cx_sq  = 22'(r_s1_cx) * 22'(r_s1_cx);
    assign w_cy_sq  = 22'(r_s1_cy) * 22'(r_s1_cy);
    assign w_rxb_sq = 24'(r_s1_rxb) * 24'(r_s1_rxb);
    assign w_ryb_sq = 24'(r_s1_ryb) * 24'(r_s1_ryb);

    logic          r_s2_vld;
    logic          r_s2_row_ok;
    logic          r_s2_bon;
    logic          r_s2_fop;
    logic          r_s2_bop;
    logic [SQ-1:0] r_s2_a2f;
    logic [SQ-1:0] r_s2_b2f;
    logic [SQ-1:0] r_s2_a2b;
    logic [SQ-1:0] r_s2_b2b;
    logic [JJ-1:0] r_s2_jj;
    logic [AW-1:0] r_s2_prod;
    logic [12:0]   r_s2_xsum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_row_ok <= r_s1_row_ok;
        r_s2_bon    <= r_s1_bon;
        r_s2_fop    <= r_s1_fop;
        r_s2_bop    <= r_s1_bop;
        r_s2_a2f    <= {1'b0, w_cx_sq};
        r_s2_b2f    <= {1'b0, w_cy_sq};
        r_s2_a2b    <= w_rxb_sq[SQ-1:0];
        r_s2_b2b    <= w_ryb_sq[SQ-1:0];
        r_s2_jj     <= 24'(r_s1_absj) * 24'(r_s1_absj);
        r_s2_prod   <= r_s1_ysum * AW'(r_s1_sw);
        r_s2_xsum   <= r_s1_xsum;
    end

    // stage 3: numerators, quotient range check, address
    logic [NUMW-1:0] w_num_f;
    logic [NUMW-1:0] w_num_b;

    assign w_num_f = NUMW'(r_s2_a2f) * NUMW'(r_s2_jj);
    assign w_num_b = NUMW'(r_s2_a2b) * NUMW'(r_s2_jj);

    logic               r_s3_vld;
    logic               r_s3_row_ok;
    logic               r_s3_bon;
    logic               r_s3_fop;
    logic               r_s3_bop;
    logic [AW-1:0]      r_s3_addr;
    ersg_pkg::t_div_req r_s3_req_f;
    ersg_pkg::t_div_req r_s3_req_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_row_ok     <= r_s2_row_ok;
        r_s3_bon        <= r_s2_bon;
        r_s3_fop        <= r_s2_fop;
        r_s3_bop        <= r_s2_bop;
        r_s3_addr       <= r_s2_prod + {11'd0, r_s2_xsum};
        r_s3_req_f.ok   <= r_s2_jj < {1'b0, r_s2_b2f};
        r_s3_req_f.num  <= w_num_f[NUMW-2:0];
        r_s3_req_f.den  <= r_s2_b2f;
        r_s3_req_f.lim  <= r_s2_a2f;
        r_s3_req_b.ok   <= r_s2_jj < {1'b0, r_s2_b2b};
        r_s3_req_b.num  <= w_num_b[NUMW-2:0];
        r_s3_req_b.den  <= r_s2_b2b;
        r_s3_req_b.lim  <= r_s2_a2b;
    end

    // fill and border lanes
    ersg_pkg::t_div_res w_res_f;
    ersg_pkg::t_div_res w_res_b;
    logic [ersg_pkg::ROOT_W-1:0] w_root_f;
    logic [ersg_pkg::ROOT_W-1:0] w_root_b;

    ersg_div u_div_fill (
        .i_clk (i_clk),
        .i_req (r_s3_req_f),
        .o_res (w_res_f)
    );

    ersg_div u_div_border (
        .i_clk (i_clk),
        .i_req (r_s3_req_b),
        .o_res (w_res_b)
    );

    ersg_sqrt u_sqrt_fill (
        .i_clk  (i_clk),
        .i_res  (w_res_f),
        .o_root (w_root_f)
    );

    ersg_sqrt u_sqrt_border (
        .i_clk  (i_clk),
        .i_res  (w_res_b),
        .o_root (w_root_b)
    );

    // sideband delay line alongside the lanes
    logic          r_sb_vld    [SB];
    logic          r_sb_row_ok [SB];
    logic          r_sb_bon    [SB];
    logic          r_sb_fop    [SB];
    logic          r_sb_bop    [SB];
    logic [AW-1:0] r_sb_addr   [SB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SB; k++) begin
                r_sb_vld[k] <= 1'b0;
            end
        end else begin
            r_sb_vld[0] <= r_s3_vld;
            for (int k = 1; k < SB; k++) begin
                r_sb_vld[k] <= r_sb_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sb_row_ok[0] <= r_s3_row_ok;
        r_sb_bon[0]    <= r_s3_bon;
        r_sb_fop[0]    <= r_s3_fop;
        r_sb_bop[0]    <= r_s3_bop;
        r_sb_addr[0]   <= r_s3_addr;
        for (int k = 1; k < SB; k++) begin
            r_sb_row_ok[k] <= r_sb_row_ok[k-1];
            r_sb_bon[k]    <= r_sb_bon[k-1];
            r_sb_fop[k]    <= r_sb_fop[k-1];
            r_sb_bop[k]    <= r_sb_bop[k-1];
            r_sb_addr[k]   <= r_sb_addr[k-1];
        end
    end

    // output stage: wider span, invalid rows read as zero
    logic [11:0] w_outer;
    logic        w_ok;

    assign w_ok    = r_sb_row_ok[SB-1];
    assign w_outer = (r_sb_bon[SB-1] && (w_root_b > w_root_f)) ? w_root_b : w_root_f;

    logic          r_valid;
    logic          r_row_valid;
    logic [AW-1:0] r_addr;
    logic [10:0]   r_fill;
    logic [11:0]   r_outer;
    logic          r_fop;
    logic          r_bop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_sb_vld[SB-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_row_valid <= w_ok;
        r_addr      <= w_ok ? r_sb_addr[SB-1] : '0;
        r_fill      <= w_ok ? w_root_f[10:0] : '0;
        r_outer     <= w_ok ? w_outer : '0;
        r_fop       <= w_ok && r_sb_fop[SB-1];
        r_bop       <= w_ok && r_sb_bop[SB-1];
    end

    assign o_valid           = r_valid;
    assign o_row_valid       = r_row_valid;
    assign o_centre_address  = r_addr;
    assign o_fill_half_span  = r_fill;
    assign o_outer_half_span = r_outer;
    assign o_fill_opaque     = r_fop;
    assign o_border_opaque   = r_bop;

    // checks
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_row_valid) |-> (o_centre_address == '0) && (o_fill_half_span == '0)
            && (o_outer_half_span == '0) && !o_fill_opaque && !o_border_opaque)
        else $error("invalid row carries nonzero fields");

    a_outer_covers_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_row_valid) |-> (o_outer_half_span >= {1'b0, o_fill_half_span}))
        else $error("outer span below fill span");

    a_border_needs_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_border_opaque) |-> o_row_valid)
        else $error("opaque border on a row not drawn");

endmodule

`default_nettype wire

>>> hdl/ersg_div.sv
`default_nettype none

module ersg_div (
    input  wire logic              i_clk,
    input  wire ersg_pkg::t_div_req i_req,
    output      ersg_pkg::t_div_res o_res
);

    localparam int unsigned W = ersg_pkg::SQ_W;
    localparam int unsigned N = ersg_pkg::DIV_STAGES;
    localparam int unsigned NUM_W_HI = ersg_pkg::NUM_W - 1;

    logic [W-1:0] r_rem [N];
    logic [W-1:0] r_num [N];
    logic [W-1:0] r_quo [N];
    logic [W-1:0] r_den [N];
    logic [W-1:0] r_lim [N];
    logic         r_ok  [N];

    // one restoring quotient bit per stage
    for (genvar k = 0; k < N; k++) begin : g_step
        logic [W-1:0] w_rem;
        logic [W-1:0] w_num;
        logic [W-1:0] w_quo;
        logic [W-1:0] w_den;
        logic [W-1:0] w_lim;
        logic         w_ok;
        logic [W:0]   w_trial;
        logic [W:0]   w_diff;

        if (k == 0) begin : g_first
            assign w_rem = i_req.num[NUM_W_HI:W];
            assign w_num = i_req.num[W-1:0];
            assign w_quo = '0;
            assign w_den = i_req.den;
            assign w_lim = i_req.lim;
            assign w_ok  = i_req.ok;
        end else begin : g_next
            assign w_rem = r_rem[k-1];
            assign w_num = r_num[k-1];
            assign w_quo = r_quo[k-1];
            assign w_den = r_den[k-1];
            assign w_lim = r_lim[k-1];
            assign w_ok  = r_ok[k-1];
        end

        assign w_trial = {w_rem, w_num[W-1]};
        assign w_diff  = w_trial - {1'b0, w_den};

        always_ff @(posedge i_clk) begin
            if (w_trial >= {1'b0, w_den}) begin
                r_rem[k] <= w_diff[W-1:0];
                r_quo[k] <= {w_quo[W-2:0], 1'b1};
            end else begin
                r_rem[k] <= w_trial[W-1:0];
                r_quo[k] <= {w_quo[W-2:0], 1'b0};
            end
            r_num[k] <= {w_num[W-2:0], 1'b0};
            r_den[k] <= w_den;
            r_lim[k] <= w_lim;
            r_ok[k]  <= w_ok;
        end
    end

    assign o_res.ok  = r_ok[N-1];
    assign o_res.lim = r_lim[N-1];
    assign o_res.quo = r_quo[N-1];

endmodule

`default_nettype wire

>>> hdl/ersg_sqrt.sv
`default_nettype none

module ersg_sqrt (
    input  wire logic                   i_clk,
    input  wire ersg_pkg::t_div_res     i_res,
    output      logic [ersg_pkg::ROOT_W-1:0] o_root
);

    localparam int unsigned RW = ersg_pkg::ROOT_W;
    localparam int unsigned XW = 2 * RW;
    localparam int unsigned N  = ersg_pkg::SQRT_STEPS;
    localparam int unsigned MW = RW + 1;

    logic [XW-1:0] r_x;
    logic [XW-1:0] r_xs   [N];
    logic [MW-1:0] r_rem  [N];
    logic [RW-1:0] r_root [N];

    // limit = a2 - quotient, zero where the row lies beyond the radius
    always_ff @(posedge i_clk) begin
        if (i_res.ok) begin
            r_x <= {1'b0, i_res.lim - i_res.quo};
        end else begin
            r_x <= '0;
        end
    end

    // one root digit per stage
    for (genvar k = 0; k < N; k++) begin : g_step
        logic [XW-1:0] w_x;
        logic [MW-1:0] w_rem;
        logic [RW-1:0] w_root;
        logic [MW+1:0] w_t;
        logic [MW+1:0] w_trial;

        if (k == 0) begin : g_first
            assign w_x    = r_x;
            assign w_rem  = '0;
            assign w_root = '0;
        end else begin : g_next
            assign w_x    = r_xs[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_root = r_root[k-1];
        end

        assign w_t     = {w_rem, w_x[XW-1:XW-2]};
        assign w_trial = {1'b0, w_root, 2'b01};

        always_ff @(posedge i_clk) begin
            if (w_t >= w_trial) begin
                r_rem[k]  <= MW'(w_t - w_trial);
                r_root[k] <= {w_root[RW-2:0], 1'b1};
            end else begin
                r_rem[k]  <= w_t[MW-1:0];
                r_root[k] <= {w_root[RW-2:0], 1'b0};
            end
            r_xs[k] <= {w_x[XW-3:0], 2'b00};
        end
    end

    // round up unless exact
    assign o_root = r_root[N-1] + RW'(r_rem[N-1] != '0);

endmodule

`default_nettype wire
